/* src/mcs_pkg.sv */
// ============================================================================
// mcs_pkg
// Types, constants and tables shared by the chord strummer block.
// ============================================================================
package mcs_pkg;

   // queue and timing constants
   localparam int QUEUE_DEPTH   = 16;
   localparam int SAMPLE_HZ     = 44100;
   localparam int MS_PER_SEC    = 1000;
   localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_RESULTS   = 16;
   localparam int ROOM_W        = 5;
   localparam int DELAY_W       = 15;
   localparam int DELAY_MAX     = 32767;
   localparam int STRUM_ENTRIES = 128;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHORD_KIND  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRUM_MS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRUM_DOWN  = 2'd2;

   // chord kinds
   localparam logic [2:0] KIND_BARE  = 3'd0;
   localparam logic [2:0] KIND_MAJ   = 3'd1;
   localparam logic [2:0] KIND_MIN   = 3'd2;
   localparam logic [2:0] KIND_FIFTH = 3'd3;
   localparam logic [2:0] KIND_OCT   = 3'd4;

   // midi codes
   localparam logic [3:0] NOTE_ON_HI  = 4'h9;
   localparam logic [3:0] NOTE_OFF_HI = 4'h8;
   localparam logic [8:0] NOTE_MAX    = 9'd127;
   localparam logic [1:0] LEN_NOTE    = 2'd3;
   localparam logic       FUNC_MSG    = 1'b0;
   localparam logic       FUNC_TICK   = 1'b1;

   // one pending queue entry
   typedef struct packed {
      logic [7:0]         st;
      logic [7:0]         nt;
      logic [7:0]         vel;
      logic signed [15:0] delay;
   } entry_type;

   // one result beat payload
   typedef struct packed {
      logic [7:0] st;
      logic [7:0] d1;
      logic [7:0] d2;
      logic [1:0] len;
   } result_type;

   // command broadcast along the cell chain
   typedef struct packed {
      logic      shift;
      logic      insert;
      logic      push;
      entry_type ins;
   } chain_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MSG,
      ST_TICK,
      ST_FLUSH
   } state_type;

   // strum delay in samples for each millisecond setting
   typedef logic [DELAY_W-1:0] strum_table_type [STRUM_ENTRIES];

   function automatic strum_table_type build_strum_table();
      strum_table_type t;
      int unsigned     v;
      for (int i = 0; i < STRUM_ENTRIES; i++) begin
         v = (i * SAMPLE_HZ) / MS_PER_SEC;
         if (v > DELAY_MAX) v = DELAY_MAX;
         t[i] = DELAY_W'(v);
      end
      return t;
   endfunction

   localparam strum_table_type STRUM_TABLE = build_strum_table();

   // number of chord notes
   function automatic logic [1:0] chord_size(input logic [2:0] kind);
      logic [1:0] n;
      case (kind)
         KIND_MAJ, KIND_MIN:  n = 2'd3;
         KIND_FIFTH, KIND_OCT: n = 2'd2;
         default:             n = 2'd1;
      endcase
      return n;
   endfunction

   // semitone offset of chord note idx
   function automatic logic [3:0] chord_interval(input logic [2:0] kind,
                                                 input logic [1:0] idx);
      logic [3:0] iv;
      iv = 4'd0;
      case (kind)
         KIND_MAJ:   iv = (idx == 2'd1) ? 4'd4 : ((idx == 2'd2) ? 4'd7 : 4'd0);
         KIND_MIN:   iv = (idx == 2'd1) ? 4'd3 : ((idx == 2'd2) ? 4'd7 : 4'd0);
         KIND_FIFTH: iv = (idx == 2'd1) ? 4'd7 : 4'd0;
         KIND_OCT:   iv = (idx == 2'd1) ? 4'd12 : 4'd0;
         default:    iv = 4'd0;
      endcase
      return iv;
   endfunction

endpackage

/* src/mcs_req_if.sv */
// ============================================================================
// mcs_req_if
// Input channel: midi message or tick beats.
// ============================================================================
interface mcs_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [1:0]  msg_len;
   logic [7:0]  status_byte;
   logic [7:0]  data_one;
   logic [7:0]  data_two;
   logic [12:0] tick_frames;
   logic [4:0]  output_room;

   modport source (output valid, func, msg_len, status_byte, data_one, data_two,
                   tick_frames, output_room, input ready);
   modport sink   (input valid, func, msg_len, status_byte, data_one, data_two,
                   tick_frames, output_room, output ready);
endinterface

/* src/mcs_rsp_if.sv */
// ============================================================================
// mcs_rsp_if
// Result channel: emitted midi messages.
// ============================================================================
interface mcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_status;
   logic [7:0] out_data_one;
   logic [7:0] out_data_two;
   logic [1:0] out_len;
   logic       last_of_run;

   modport source (output valid, out_status, out_data_one, out_data_two, out_len,
                   last_of_run, input ready);
   modport sink   (input valid, out_status, out_data_one, out_data_two, out_len,
                   last_of_run, output ready);
endinterface

/* src/mcs_csr_if.sv */
// ============================================================================
// mcs_csr_if
// Configuration write channel.
// ============================================================================
interface mcs_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/midi_chord_strummer_unit.sv */
// ============================================================================
// midi_chord_strummer_unit
// Chord generator with strum delay over a chain of pending queue cells.
//
//   channel   dir   handshake        payload
//   req_chan  in    valid / ready    func, msg_len, status_byte, data_one,
//                                    data_two, tick_frames, output_room
//   rsp_chan  out   valid / ready    out_status, out_data_one, out_data_two,
//                                    out_len, last_of_run
//   csr_chan  in    valid / ready    index, data (ready always high)
//
// One item at a time. A pass-through message goes from idle straight to the
// flush state; a note on or off takes one sequencer step per chord note, one
// to close the run and one to flush; a tick walks each filled cell (the
// head cell is examined once per cycle while the chain rotates and the output
// does not stall). A one-deep hold stage ahead of the output register marks
// the final result; a stalled output stops the sequencer at the next result.
// Synchronous reset empties the queue and restores the register defaults.
// ============================================================================
module midi_chord_strummer_unit
   import mcs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mcs_req_if.sink   req_chan,
   mcs_rsp_if.source rsp_chan,
   mcs_csr_if.sink   csr_chan
);

   chain_cmd_type cmd;
   logic          cell_valid [QUEUE_DEPTH+1];
   entry_type     cell_data  [QUEUE_DEPTH+1];

   mcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .csr   (csr_chan),
      .head  (cell_data[0]),
      .cmd   (cmd)
   );

   // end of chain is always empty
   assign cell_valid[QUEUE_DEPTH] = 1'b0;
   assign cell_data[QUEUE_DEPTH]  = '0;

   // row of queue cells, head at index zero
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic prev_valid;
      if (k == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = cell_valid[k-1];
      end

      mcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prev_valid),
         .next_valid (cell_valid[k+1]),
         .next_data  (cell_data[k+1]),
         .valid      (cell_valid[k]),
         .data       (cell_data[k])
      );
   end

endmodule

/* src/mcs_cell.sv */
// ============================================================================
// mcs_cell
// One pending queue cell: holds an entry, shifts toward the head or takes
// a new entry when it is the first free cell or the tail slot of a shift.
// ============================================================================
module mcs_cell
   import mcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  logic          prev_valid,
   input  logic          next_valid,
   input  entry_type     next_data,
   output logic          valid,
   output entry_type     data
);

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;

   // next cell contents
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.shift) begin
         if (next_valid) begin
            valid_in = 1'b1;
            data_in  = next_data;
         end else begin
            // last occupied cell becomes the tail slot
            valid_in = valid_ff && cmd.insert;
            data_in  = cmd.ins;
         end
      end else if (cmd.push && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         data_in  = cmd.ins;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

/* src/mcs_ctrl.sv */
// ============================================================================
// mcs_ctrl
// Sequencer: configuration registers, chord expansion, tick walk over the
// cell chain, result hold stage and output register.
// ============================================================================
module mcs_ctrl
   import mcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mcs_req_if.sink       req,
   mcs_rsp_if.source     rsp,
   mcs_csr_if.sink       csr,
   input  entry_type     head,
   output chain_cmd_type cmd
);

   state_type state_ff, state_in;

   logic [2:0]  kind_ff, kind_in;
   logic [6:0]  strum_ms_ff, strum_ms_in;
   logic        down_ff, down_in;

   logic [7:0]  st_ff, st_in;
   logic [7:0]  d1_ff, d1_in;
   logic [7:0]  d2_ff, d2_in;
   logic [12:0] frames_ff, frames_in;
   logic [ROOM_W-1:0] room_ff, room_in;
   logic [ROOM_W-1:0] count_ff, count_in;
   logic [1:0]  step_ff, step_in;
   logic [1:0]  num_ff, num_in;
   logic [DELAY_W-1:0] strum_ff, strum_in;
   logic [FILL_W-1:0]  walk_ff, walk_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   result_type  held_ff, held_in;
   logic        held_v_ff, held_v_in;
   result_type  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_v_ff, rsp_v_in;

   logic        out_free, can_gen, gen;
   result_type  gen_data;
   logic [ROOM_W-1:0] room_cap;
   logic        is_note;

   // message step datapath
   logic [1:0]  idx;
   logic [8:0]  note;
   logic [16:0] delay_raw;
   logic [DELAY_W-1:0] delay_sat;

   // tick datapath
   logic signed [16:0] diff;
   logic signed [15:0] w_sat;
   localparam logic signed [16:0] SAT_LOW = -17'sd32768;

   assign csr.ready   = 1'b1;
   assign req.ready   = (state_ff == ST_IDLE);
   assign out_free    = !rsp_v_ff || rsp.ready;
   assign can_gen     = !held_v_ff || out_free;
   assign room_cap    = (req.output_room > ROOM_W'(MAX_RESULTS)) ?
                        ROOM_W'(MAX_RESULTS) : req.output_room;
   assign is_note     = (req.status_byte[7:4] inside {NOTE_ON_HI, NOTE_OFF_HI}) &&
                        (req.msg_len == LEN_NOTE);

   // chord note of the current step
   assign idx       = down_ff ? (num_ff - 2'd1 - step_ff) : step_ff;
   assign note      = {1'b0, d1_ff} + {5'd0, chord_interval(kind_ff, idx)};
   assign delay_raw = (step_ff == 2'd0) ? 17'd0 :
                      ((step_ff == 2'd1) ? {2'd0, strum_ff} : {1'b0, strum_ff, 1'b0});
   assign delay_sat = (delay_raw > 17'(DELAY_MAX)) ? DELAY_W'(DELAY_MAX)
                                                    : delay_raw[DELAY_W-1:0];

   // saturating countdown of the head entry
   assign diff  = {head.delay[15], head.delay} - $signed({4'd0, frames_ff});
   assign w_sat = (diff < SAT_LOW) ? SAT_LOW[15:0] : diff[15:0];

   // next state and datapath control
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      strum_ms_in = strum_ms_ff;
      down_in     = down_ff;
      st_in       = st_ff;
      d1_in       = d1_ff;
      d2_in       = d2_ff;
      frames_in   = frames_ff;
      room_in     = room_ff;
      count_in    = count_ff;
      step_in     = step_ff;
      num_in      = num_ff;
      strum_in    = strum_ff;
      walk_in     = walk_ff;
      fill_in     = fill_ff;
      held_in     = held_ff;
      held_v_in   = held_v_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_v_in    = rsp_v_ff;
      gen         = 1'b0;
      gen_data    = '0;
      cmd         = '0;

      // configuration beat
      if (csr.valid) begin
         case (csr.index)
            CSR_CHORD_KIND: kind_in     = csr.data[2:0];
            CSR_STRUM_MS:   strum_ms_in = csr.data;
            CSR_STRUM_DOWN: down_in     = csr.data[0];
            default:        ;
         endcase
      end

      // output register drains
      if (rsp.ready) rsp_v_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               st_in     = req.status_byte;
               d1_in     = req.data_one;
               d2_in     = req.data_two;
               frames_in = req.tick_frames;
               room_in   = room_cap;
               count_in  = '0;
               step_in   = 2'd0;
               num_in    = chord_size(kind_ff);
               strum_in  = STRUM_TABLE[strum_ms_ff];
               walk_in   = fill_ff;
               if (room_cap == '0) begin
                  state_in = ST_IDLE;
               end else if (req.func == FUNC_TICK) begin
                  if (fill_ff != '0) state_in = ST_TICK;
               end else if (req.msg_len == 2'd0) begin
                  state_in = ST_IDLE;
               end else if (!is_note) begin
                  held_in.st  = req.status_byte;
                  held_in.d1  = (req.msg_len > 2'd1) ? req.data_one : 8'd0;
                  held_in.d2  = (req.msg_len > 2'd2) ? req.data_two : 8'd0;
                  held_in.len = req.msg_len;
                  held_v_in   = 1'b1;
                  state_in    = ST_FLUSH;
               end else if (kind_ff == KIND_BARE) begin
                  held_in   = '{st: req.status_byte, d1: req.data_one,
                                d2: req.data_two, len: LEN_NOTE};
                  held_v_in = 1'b1;
                  state_in  = ST_FLUSH;
               end else begin
                  state_in = ST_MSG;
               end
            end
         end

         // one chord note per cycle unless the output stalls
         ST_MSG: begin
            if (step_ff == num_ff || count_ff == room_ff) begin
               state_in = ST_FLUSH;
            end else if (note > NOTE_MAX) begin
               step_in = step_ff + 2'd1;
            end else if (delay_sat == '0) begin
               if (can_gen) begin
                  gen      = 1'b1;
                  gen_data = '{st: st_ff, d1: note[7:0], d2: d2_ff, len: LEN_NOTE};
                  count_in = count_ff + ROOM_W'(1);
                  step_in  = step_ff + 2'd1;
               end
            end else begin
               if (fill_ff < FILL_W'(QUEUE_DEPTH)) begin
                  cmd.push = 1'b1;
                  cmd.ins  = '{st: st_ff, nt: note[7:0], vel: d2_ff,
                               delay: $signed({1'b0, delay_sat})};
                  fill_in  = fill_ff + FILL_W'(1);
               end
               step_in = step_ff + 2'd1;
            end
         end

         // walk the queue once, head entry per cycle unless the output stalls
         ST_TICK: begin
            if (walk_ff == '0) begin
               state_in = ST_FLUSH;
            end else if ((w_sat <= 16'sd0) && (count_ff < room_ff)) begin
               if (can_gen) begin
                  gen       = 1'b1;
                  gen_data  = '{st: head.st, d1: head.nt, d2: head.vel, len: LEN_NOTE};
                  cmd.shift = 1'b1;
                  count_in  = count_ff + ROOM_W'(1);
                  fill_in   = fill_ff - FILL_W'(1);
                  walk_in   = walk_ff - FILL_W'(1);
               end
            end else begin
               cmd.shift  = 1'b1;
               cmd.insert = 1'b1;
               cmd.ins    = '{st: head.st, nt: head.nt, vel: head.vel, delay: w_sat};
               walk_in    = walk_ff - FILL_W'(1);
            end
         end

         // last result goes out marked
         ST_FLUSH: begin
            if (!held_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_data_in = held_ff;
               rsp_last_in = 1'b1;
               held_v_in   = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // new result pushes the held one out
      if (gen) begin
         if (held_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_data_in = held_ff;
            rsp_last_in = 1'b0;
         end
         held_in   = gen_data;
         held_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         kind_ff     <= KIND_MAJ;
         strum_ms_ff <= '0;
         down_ff     <= 1'b0;
         fill_ff     <= '0;
         held_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
         count_ff    <= '0;
         step_ff     <= '0;
         walk_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         strum_ms_ff <= strum_ms_in;
         down_ff     <= down_in;
         fill_ff     <= fill_in;
         held_v_ff   <= held_v_in;
         rsp_v_ff    <= rsp_v_in;
         count_ff    <= count_in;
         step_ff     <= step_in;
         walk_ff     <= walk_in;
      end
      st_ff       <= st_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      frames_ff   <= frames_in;
      room_ff     <= room_in;
      num_ff      <= num_in;
      strum_ff    <= strum_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid        = rsp_v_ff;
   assign rsp.out_status   = rsp_data_ff.st;
   assign rsp.out_data_one = rsp_data_ff.d1;
   assign rsp.out_data_two = rsp_data_ff.d2;
   assign rsp.out_len      = rsp_data_ff.len;
   assign rsp.last_of_run  = rsp_last_ff;

endmodule
